>>> hdl/salru_pkg.sv
// Shared types and constants for the set-associative LRU cache lookup block.
// Depends on nothing; every other file of the block but salru_rsp_if imports it.
`default_nettype none
package salru_pkg;

  localparam int KEY_W       = 31;
  localparam int WAYS_CFG_W  = 3;
  localparam int MAX_SET_W   = 12;
  localparam int DEF_SETS    = 64;
  localparam int DEF_WAYS    = 4;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = QPTR_W + 1;
  localparam logic [WAYS_CFG_W-1:0] WAYS_RESET = WAYS_CFG_W'(4);

  typedef struct packed {
    logic [MAX_SET_W-1:0] set;
    logic [KEY_W-1:0]     key;
  } salru_item_t;

  // Front to back: head of the lookup queue.
  typedef struct packed {
    logic        valid;
    salru_item_t item;
  } salru_head_t;

  // Back to front: queue pop and clearing status.
  typedef struct packed {
    logic pop;
    logic clearing;
  } salru_ctrl_t;

endpackage
`default_nettype wire

>>> hdl/salru_req_if.sv
// Request channel of the cache lookup block: valid, ready and the key.
// Depends on salru_pkg.
`default_nettype none
interface salru_req_if;
  import salru_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink (input valid, input key, output ready);
endinterface
`default_nettype wire

>>> hdl/salru_rsp_if.sv
// Response channel of the cache lookup block: valid, ready and the hit flag.
// Depends on nothing.
`default_nettype none
interface salru_rsp_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, output hit, input ready);
  modport sink (input valid, input hit, output ready);
endinterface
`default_nettype wire

>>> hdl/set_assoc_lru_cache_lookup.sv
// Top level of the set-associative LRU cache lookup block.
// Depends on salru_pkg, salru_req_if, salru_rsp_if, salru_front, salru_back.
//
// Each request transaction carries a key; its set is the key modulo SETS, and
// the response transaction reports whether the key was already held in that
// set, after which the key is the most recently used one there (inserted on a
// miss, evicting the least recently used key when the set holds ways_in_use
// keys, with ways_in_use of zero read as one and above WAYS read as WAYS).
// After reset the block runs a clearing pass over the set store and accepts
// no request until it ends; cfg_we/cfg_wdata may be written only while no
// transaction is in flight. The front end takes one request per cycle, while
// the queue has room, into a one-stage set-index register that feeds a
// four-entry queue. The back end takes each transaction through a registered
// read of the single-port set store, then update and write, and takes no new
// transaction until that write is done.
`default_nettype none
module set_assoc_lru_cache_lookup #(
  parameter int SETS = salru_pkg::DEF_SETS,
  parameter int WAYS = salru_pkg::DEF_WAYS
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire [salru_pkg::WAYS_CFG_W-1:0] cfg_wdata,
  salru_req_if.sink                       req,
  salru_rsp_if.source                     rsp
);
  import salru_pkg::*;

  salru_head_t head;
  salru_ctrl_t ctrl;

  salru_front #(
    .SETS (SETS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .ctrl (ctrl),
    .head (head)
  );

  salru_back #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .ctrl      (ctrl),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

>>> hdl/salru_front.sv
// Front end: accepts lookup transactions, computes the set index of each key
// and queues the classified transactions. Depends on salru_pkg, salru_req_if.
`default_nettype none
module salru_front #(
  parameter int SETS = salru_pkg::DEF_SETS
) (
  input  wire                    clk,
  input  wire                    rst,
  salru_req_if.sink              req,
  input  salru_pkg::salru_ctrl_t ctrl,
  output salru_pkg::salru_head_t head
);
  import salru_pkg::*;

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int RW     = SET_W + 1;
  localparam int PROD_W = KEY_W + 32;
  localparam logic [31:0] RECIP = 32'((64'd1 << 31) / SETS);
  localparam logic [RW-1:0] SETS_RW = RW'(SETS);

  logic                s1_valid;
  logic [KEY_W-1:0]    s1_key;
  logic [PROD_W-1:0]   s1_prod;
  logic [RW-1:0]       quot_low;
  logic [RW-1:0]       rem_raw;
  logic [RW-1:0]       rem;
  logic                accept;
  logic                push;
  salru_item_t         queue [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QCNT_W-1:0]   count_next;

  assign req.ready = !ctrl.clearing && ((count + QCNT_W'(s1_valid)) < QCNT_W'(QDEPTH));
  assign accept    = req.valid && req.ready;

  // The quotient estimate is exact or one short, so the remainder is below
  // twice the set count and fits in the low bits.
  assign quot_low = s1_prod[31 +: RW];
  assign rem_raw  = s1_key[RW-1:0] - RW'(quot_low * SETS_RW);
  assign rem      = (rem_raw >= SETS_RW) ? rem_raw - SETS_RW : rem_raw;
  assign push     = s1_valid;

  always_comb begin
    count_next = count;
    if (push && !ctrl.pop) begin
      count_next = count + 1'b1;
    end else if (!push && ctrl.pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
    end else begin
      s1_valid <= accept;
      count    <= count_next;
      if (accept) begin
        s1_key  <= req.key;
        s1_prod <= PROD_W'(req.key) * PROD_W'(RECIP);
      end
      if (push) begin
        queue[wr_ptr] <= '{set: MAX_SET_W'(rem), key: s1_key};
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (ctrl.pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  assign head.valid = (count != '0);
  assign head.item  = queue[rd_ptr];

endmodule
`default_nettype wire

>>> hdl/salru_back.sv
// Back end: per-set key store with LRU order, read-modify-write of one set
// per transaction, clearing pass after reset and the response register.
// Depends on salru_pkg, salru_rsp_if.
`default_nettype none
module salru_back #(
  parameter int SETS = salru_pkg::DEF_SETS,
  parameter int WAYS = salru_pkg::DEF_WAYS
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_we,
  input  wire [salru_pkg::WAYS_CFG_W-1:0]      cfg_wdata,
  input  salru_pkg::salru_head_t               head,
  output salru_pkg::salru_ctrl_t               ctrl,
  salru_rsp_if.source                          rsp
);
  import salru_pkg::*;

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int OCC_W = $clog2(WAYS + 1);
  localparam int KEYS_W = WAYS * KEY_W;
  localparam int ROW_W = OCC_W + KEYS_W;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK} state_t;

  state_t                          state;
  logic [SET_W-1:0]                clr;
  logic [WAYS_CFG_W-1:0]           ways_in_use;
  logic [KEY_W-1:0]                cur_key;
  logic [SET_W-1:0]                cur_set;
  logic                            out_valid;
  logic                            hit_r;
  logic                            pop;
  logic [ROW_W-1:0]                mem [SETS];
  logic [ROW_W-1:0]                rd_row;
  logic                            mem_we;
  logic [SET_W-1:0]                mem_wa;
  logic [ROW_W-1:0]                mem_wd;
  logic [OCC_W-1:0]                occ;
  logic [OCC_W-1:0]                eff;
  logic [OCC_W-1:0]                occ_new;
  logic [OCC_W-1:0]                rm_pos;
  logic [WAYS-1:0][KEY_W-1:0]      keys;
  logic [WAYS-1:0][KEY_W-1:0]      shifted;
  logic [WAYS-1:0][KEY_W-1:0]      keys_new;
  logic [WAYS-1:0]                 match;
  logic                            hit_c;
  logic                            append;

  assign pop = (state == S_IDLE) && head.valid && (!out_valid || rsp.ready);
  assign ctrl.pop      = pop;
  assign ctrl.clearing = (state == S_CLEAR);
  assign rsp.valid     = out_valid;
  assign rsp.hit       = hit_r;

  always_comb begin
    if (ways_in_use == '0) begin
      eff = OCC_W'(1);
    end else if (int'(ways_in_use) > WAYS) begin
      eff = OCC_W'(WAYS);
    end else begin
      eff = OCC_W'(ways_in_use);
    end
  end

  always_comb begin
    occ     = rd_row[KEYS_W +: OCC_W];
    keys    = rd_row[KEYS_W-1:0];
    shifted = keys >> KEY_W;
    rm_pos  = '0;
    hit_c   = 1'b0;
    for (int j = 0; j < WAYS; j++) begin
      match[j] = (OCC_W'(j) < occ) && (keys[j] == cur_key);
    end
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (match[j]) begin
        rm_pos = OCC_W'(j);
        hit_c  = 1'b1;
      end
    end
    append  = !hit_c && (occ < eff);
    occ_new = append ? OCC_W'(occ + 1'b1) : occ;
    for (int j = 0; j < WAYS; j++) begin
      if (append) begin
        keys_new[j] = (OCC_W'(j) == occ) ? cur_key : keys[j];
      end else if (OCC_W'(j) < rm_pos) begin
        keys_new[j] = keys[j];
      end else if (OCC_W'(j + 1) < occ) begin
        keys_new[j] = shifted[j];
      end else if (OCC_W'(j + 1) == occ) begin
        keys_new[j] = cur_key;
      end else begin
        keys_new[j] = keys[j];
      end
    end
  end

  always_comb begin
    mem_we = (state == S_CLEAR) || (state == S_LOOK);
    mem_wa = (state == S_CLEAR) ? clr : cur_set;
    mem_wd = (state == S_CLEAR) ? '0 : {occ_new, keys_new};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (pop) begin
      rd_row <= mem[head.item.set[SET_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr         <= '0;
      out_valid   <= 1'b0;
      ways_in_use <= WAYS_RESET;
    end else begin
      if (cfg_we) begin
        ways_in_use <= cfg_wdata;
      end
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == SET_W'(SETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            cur_key <= head.item.key;
            cur_set <= head.item.set[SET_W-1:0];
            state   <= S_LOOK;
          end
        end
        S_LOOK: begin
          out_valid <= 1'b1;
          hit_r     <= hit_c;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/salru_checker.sv
// Port-level checks for the cache lookup block, and the bind that attaches
// them to the top level. Depends on salru_pkg and set_assoc_lru_cache_lookup.
`default_nettype none
module salru_checker (
  input wire clk,
  input wire rst,
  input wire req_valid,
  input wire req_ready,
  input wire rsp_valid,
  input wire rsp_ready,
  input wire rsp_hit
);
  import salru_pkg::*;

  logic       req_take;
  logic       rsp_take;
  logic [7:0] pending;

  assign req_take = req_valid && req_ready;
  assign rsp_take = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 8'(req_take) - 8'(rsp_take);
    end
  end

  // A response transaction always answers an earlier request transaction.
  a_rsp_has_req: assert property (@(posedge clk) disable iff (rst)
    rsp_take |-> (pending != '0))
    else $error("response without an outstanding request");

  // The number of transactions in flight is bounded by the queue and stages.
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 8'(QDEPTH + 3))
    else $error("too many transactions in flight");

  // No request is taken in the first cycle after reset, while the store clears.
  a_no_req_after_rst: assert property (@(posedge clk)
    $past(rst) && !rst |-> !req_ready)
    else $error("request accepted during the clearing pass");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit))
    else $error("stalled response changed");

endmodule

bind set_assoc_lru_cache_lookup salru_checker u_salru_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_hit   (rsp.hit)
);
`default_nettype wire
